>>> rtl/lcld_pkg.sv
// Shared types, codes and prefix patterns of the length-counted line deframer.
package lcld_pkg;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 8;
    localparam int LEN_W   = 16;
    localparam int CFG_W   = 8;

    // Default line limit (line_position saturates one below it)
    localparam int LINE_LIMIT_DEF = 255;

    // Prefix geometry
    localparam int BLE_LEN   = 9;
    localparam int SER_LEN   = 14;
    localparam int NIB_FIRST = 9;

    localparam logic [BYTE_W-1:0] CR_BYTE   = 8'h0d;
    localparam logic [BYTE_W-1:0] WILD_CHAR = 8'h3f;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_BUDGET    = 1'b0,
        CFG_BLE_BYTES = 1'b1
    } cfg_index_t;

    // Input command codes
    typedef enum logic [0:0] {
        CMD_BYTE  = 1'b0,
        CMD_ABORT = 1'b1
    } command_t;

    // How a line ended
    typedef enum logic [1:0] {
        END_NONE  = 2'd0,
        END_CR    = 2'd1,
        END_ABORT = 2'd2
    } line_end_t;

    // Kind of the current line
    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_LENGTH = 2'd1,
        KIND_BLE    = 2'd2
    } frame_kind_t;

    // Per-line state kept between bytes
    typedef struct packed {
        logic [POS_W-1:0]  line_pos;
        logic              ble_prefix_ok;
        logic              serial_prefix_ok;
        logic [LEN_W-1:0]  length_nibbles;
        logic [POS_W-1:0]  payload_counter;
        frame_kind_t       line_kind;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        line_pos:         '0,
        ble_prefix_ok:    1'b1,
        serial_prefix_ok: 1'b1,
        length_nibbles:   '0,
        payload_counter:  '0,
        line_kind:        KIND_PLAIN
    };

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [POS_W-1:0]  line_position;
        logic              in_payload;
        line_end_t         line_end;
        frame_kind_t       frame_kind;
        logic [LEN_W-1:0]  payload_length;
        logic              length_error;
    } result_t;

    // "RECV BLE "
    function automatic logic [BYTE_W-1:0] ble_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h52;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h56;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h42;
            4'd6:    c = 8'h4c;
            4'd7:    c = 8'h45;
            4'd8:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "RECV ??P ???? " with '?' as wildcard
    function automatic logic [BYTE_W-1:0] ser_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h52;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h56;
            4'd4:    c = 8'h20;
            4'd5:    c = WILD_CHAR;
            4'd6:    c = WILD_CHAR;
            4'd7:    c = 8'h50;
            4'd8:    c = 8'h20;
            4'd9:    c = WILD_CHAR;
            4'd10:   c = WILD_CHAR;
            4'd11:   c = WILD_CHAR;
            4'd12:   c = WILD_CHAR;
            4'd13:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/lcld_step.sv
// Per-byte step of the deframer: prefix match, length capture, payload counting.
module lcld_step #(
    parameter int LINE_LIMIT = lcld_pkg::LINE_LIMIT_DEF
) (
    input  lcld_pkg::state_t                 state,
    input  logic [lcld_pkg::CFG_W-1:0]       payload_budget,
    input  logic [lcld_pkg::CFG_W-1:0]       ble_frame_bytes,
    input  logic                             command,
    input  logic [lcld_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             collecting,
    output lcld_pkg::state_t                 state_next,
    output lcld_pkg::result_t                result
);
    import lcld_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LIMIT - 1);

    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] b;
    logic              ble_ok;
    logic              ser_ok;
    logic              ble_m;
    logic              ser_m;
    logic [LEN_W-1:0]  nib;
    logic [POS_W-1:0]  cnt;
    logic              cnt_open;
    logic              len_fits;
    logic              counted;
    logic              err;
    logic              cr_end;
    logic [BYTE_W-1:0] ble_exp;
    logic [BYTE_W-1:0] ser_exp;
    frame_kind_t       kind;

    assign b   = data_byte;
    assign pos = (state.line_pos > POS_MAX) ? POS_MAX : state.line_pos;

    // Prefix comparison; a zero byte never matches
    assign ble_exp = ble_char(pos[3:0]);
    assign ser_exp = ser_char(pos[3:0]);

    always_comb
    begin
        ble_ok = state.ble_prefix_ok;
        if (pos < POS_W'(BLE_LEN))
        begin
            ble_ok = state.ble_prefix_ok && (b != '0) && (b == ble_exp);
        end
        ser_ok = state.serial_prefix_ok;
        if (pos < POS_W'(SER_LEN))
        begin
            ser_ok = state.serial_prefix_ok && (b != '0) &&
                     ((ser_exp == WILD_CHAR) || (b == ser_exp));
        end
    end

    // Length digits: low nibble of each, first digit in the top nibble
    always_comb
    begin
        nib = state.length_nibbles;
        case (pos)
            POS_W'(NIB_FIRST):     nib = nib | {b[3:0], 12'h000};
            POS_W'(NIB_FIRST + 1): nib = nib | {4'h0, b[3:0], 8'h00};
            POS_W'(NIB_FIRST + 2): nib = nib | {8'h00, b[3:0], 4'h0};
            POS_W'(NIB_FIRST + 3): nib = nib | {12'h000, b[3:0]};
            default:               nib = nib;
        endcase
    end

    assign ble_m    = ble_ok && (pos >= POS_W'(BLE_LEN - 1));
    assign ser_m    = ser_ok && (pos >= POS_W'(SER_LEN - 1));
    assign kind     = ble_m ? KIND_BLE : (ser_m ? KIND_LENGTH : KIND_PLAIN);
    assign cnt_open = state.payload_counter < payload_budget;
    assign len_fits = ({1'b0, nib} + 17'd1) < {9'd0, payload_budget};

    // Payload counter
    always_comb
    begin
        cnt     = state.payload_counter;
        counted = 1'b0;
        err     = 1'b0;
        cr_end  = 1'b0;
        if (collecting && ble_m && cnt_open)
        begin
            counted = 1'b1;
            if (state.payload_counter == '0)
                cnt = payload_budget - ble_frame_bytes;
            else
                cnt = state.payload_counter + POS_W'(1);
        end
        else if (collecting && ser_m && cnt_open)
        begin
            counted = 1'b1;
            if (state.payload_counter == '0)
            begin
                if (len_fits)
                begin
                    cnt = payload_budget - nib[POS_W-1:0];
                end
                else
                begin
                    cnt = POS_W'(1);
                    err = 1'b1;
                end
            end
            else
            begin
                cnt = state.payload_counter + POS_W'(1);
            end
        end
        else if (b == CR_BYTE)
        begin
            cr_end = 1'b1;
        end
    end

    // Next state and result
    always_comb
    begin
        if (command == CMD_ABORT)
        begin
            state_next = STATE_CLEAR;
            result     = '{byte_out: '0, line_position: '0, in_payload: 1'b0,
                           line_end: END_ABORT, frame_kind: KIND_PLAIN,
                           payload_length: '0, length_error: 1'b0};
        end
        else
        begin
            if (cr_end)
            begin
                state_next = STATE_CLEAR;
            end
            else
            begin
                state_next.line_pos         = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;
                state_next.ble_prefix_ok    = ble_ok;
                state_next.serial_prefix_ok = ser_ok;
                state_next.length_nibbles   = nib;
                state_next.payload_counter  = cnt;
                state_next.line_kind        = kind;
            end
            result.byte_out       = b;
            result.line_position  = pos;
            result.in_payload     = counted;
            result.line_end       = cr_end ? END_CR : END_NONE;
            result.frame_kind     = kind;
            result.payload_length = nib;
            result.length_error   = err;
        end
    end

endmodule

>>> rtl/length_counted_line_deframer_unit.sv
// Top level of the length-counted line deframer: state, configuration and output buffer.
// Takes one received byte (or an abort command) per cycle while in_stall is low and
// returns one result per input. The per-byte step (prefix compare, length digit capture,
// payload counting) is a single pass of logic between the line state register and the
// result register, so the sustained rate is one item per clock without output stalls. A
// two-entry output buffer (result register plus skid register) keeps input transfers
// going for one extra item while the output side stalls; in_stall rises once both
// entries are full. Configuration writes land at the clock edge where cfg_we is high.
module length_counted_line_deframer_unit #(
    parameter int LINE_LIMIT = lcld_pkg::LINE_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [lcld_pkg::CFG_W-1:0]      cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [lcld_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            collecting,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lcld_pkg::BYTE_W-1:0]     byte_out,
    output logic [lcld_pkg::POS_W-1:0]      line_position,
    output logic                            in_payload,
    output logic [1:0]                      line_end,
    output logic [1:0]                      frame_kind,
    output logic [lcld_pkg::LEN_W-1:0]      payload_length,
    output logic                            length_error
);
    import lcld_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LIMIT - 1);

    logic [CFG_W-1:0] budget_reg;
    logic [CFG_W-1:0] ble_bytes_reg;
    state_t           state_reg;
    state_t           state_next;
    result_t          step_result;
    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_xfer;
    logic             out_free;

    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= 8'd240;
            ble_bytes_reg <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BUDGET:    budget_reg    <= cfg_data;
                CFG_BLE_BYTES: ble_bytes_reg <= cfg_data;
                default:       budget_reg    <= budget_reg;
            endcase
        end
    end

    // Per-byte step
    lcld_step #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_step (
        .state           (state_reg),
        .payload_budget  (budget_reg),
        .ble_frame_bytes (ble_bytes_reg),
        .command         (command),
        .data_byte       (data_byte),
        .collecting      (collecting),
        .state_next      (state_next),
        .result          (step_result)
    );

    // Line state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEAR;
        else if (in_xfer)
            state_reg <= state_next;
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer data
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_xfer)
                out_reg <= step_result;
        end
        else if (in_xfer)
        begin
            skid_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_out       = out_reg.byte_out;
    assign line_position  = out_reg.line_position;
    assign in_payload     = out_reg.in_payload;
    assign line_end       = out_reg.line_end;
    assign frame_kind     = out_reg.frame_kind;
    assign payload_length = out_reg.payload_length;
    assign length_error   = out_reg.length_error;

`ifndef SYNTHESIS
    // Skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a held result");

    // Abort clears the line position
    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && command == CMD_ABORT) |=> (state_reg.line_pos == '0))
        else $error("line state not cleared after abort");

    // Line position stays within the limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.line_position <= POS_MAX))
        else $error("line_position beyond limit");

    // A counted payload byte never ends the line
    a_payload_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.in_payload) |-> (out_reg.line_end == END_NONE))
        else $error("payload byte ended a line");

    // A length error only comes with a counted byte
    a_err_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.length_error) |-> out_reg.in_payload)
        else $error("length error on an uncounted byte");
`endif

endmodule
